// ----- sv/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctc_pkg - shared types and constants of the credential table
// Field widths, operation and status codes and reset values used by the
// table, its compare unit, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    // field widths
    localparam int OP_W        = 3;
    localparam int ID_W        = 32;
    localparam int ROLE_W      = 3;
    localparam int LEN_W       = 6;
    localparam int TIME_W      = 32;
    localparam int LIFE_W      = 32;
    localparam int EXPIRY_W    = 33;
    localparam int WORD_W      = 64;
    localparam int STATUS_W    = 3;
    localparam int USED_W      = 5;

    // token layout
    localparam int BYTE_W      = 8;
    localparam int WORD_BYTES  = WORD_W / BYTE_W;
    localparam int TOKEN_WORDS = 4;
    localparam int TOKEN_BYTES = TOKEN_WORDS * WORD_BYTES;
    localparam int WSEL_W      = $clog2(TOKEN_WORDS);
    localparam int STEP_W      = $clog2(TOKEN_WORDS + 1);
    localparam int NB_W        = $clog2(WORD_BYTES + 1);
    localparam int ID_BYTES    = ID_W / BYTE_W;

    // lifetime register after reset, in seconds
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(3600);

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER     = 3'd0,
        OP_REVOKE       = 3'd1,
        OP_AUTHENTICATE = 3'd2,
        OP_AUTHORIZE    = 3'd3,
        OP_CLEAR        = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_AUTH    = 3'd2,
        ST_EXPIRED = 3'd3,
        ST_DENIED  = 3'd4,
        ST_FAIL    = 3'd5
    } status_t;

endpackage

`default_nettype wire

// ----- sv/ctc_if.sv -----
// ----------------------------------------------------------------------------
// ctc_if - channel interfaces of the credential table
// Request, response and lifetime write channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctc_req_if;
    import ctc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     user_id;
    logic [ROLE_W-1:0]   role;
    logic [LEN_W-1:0]    match_len;
    logic [TIME_W-1:0]   now;
    logic [WORD_W-1:0]   token_word0;
    logic [WORD_W-1:0]   token_word1;
    logic [WORD_W-1:0]   token_word2;
    logic [WORD_W-1:0]   token_word3;

    modport source (
        output valid, op, user_id, role, match_len, now,
               token_word0, token_word1, token_word2, token_word3,
        input  ready
    );
    modport sink (
        input  valid, op, user_id, role, match_len, now,
               token_word0, token_word1, token_word2, token_word3,
        output ready
    );
endinterface

interface ctc_rsp_if;
    import ctc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [USED_W-1:0]   entries_used;

    modport source (output valid, status, entries_used, input ready);
    modport sink   (input valid, status, entries_used, output ready);
endinterface

interface ctc_cfg_if;
    import ctc_pkg::*;

    logic                valid;
    logic                ready;
    logic [LIFE_W-1:0]   token_lifetime;

    modport source (output valid, token_lifetime, input ready);
    modport sink   (input valid, token_lifetime, output ready);
endinterface

`default_nettype wire

// ----- sv/credential_table_check.sv -----
// ----------------------------------------------------------------------------
// credential_table_check - credential table with register, revoke,
// authenticate, authorize and clear
// A small sequencer scans the table one entry a cycle through a shared
// masked compare unit, then copies, writes or checks token words one a cycle.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  req     | in  | valid / ready | op, user_id, role, match_len, now, token 0..3
//  rsp     | out | valid / ready | status, entries_used
//  cfg     | in  | valid / ready | token_lifetime (always ready)
//
//  One request at a time: req.ready is high only while the sequencer idles.
//  The id scan reads entries up to the hit, or all stored entries; then
//  token words are written on register, copied on revoke and compared on
//  authenticate, one word at a time; the single read port of each table
//  memory sets this pace. Clear and rejected requests skip the scan.
//  After reset the table is empty and the lifetime is 3600; no clearing pass.
//  The response sits in an output register; a stalled rsp holds the
//  sequencer in its last state until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module credential_table_check #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ctc_req_if.sink   req,
    ctc_rsp_if.source rsp,
    ctc_cfg_if.sink   cfg
);
    import ctc_pkg::*;

    localparam int IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW      = $clog2(TABLE_DEPTH + 1);
    localparam int TAW     = IW + WSEL_W;
    localparam int TDEPTH  = TABLE_DEPTH * TOKEN_WORDS;
    localparam int META_W  = ID_W + ROLE_W + EXPIRY_W;
    localparam logic [CW-1:0]     DEPTH_C   = CW'(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TOKEN_WORDS - 1);
    localparam logic [STEP_W-1:0] STEP_END  = STEP_W'(TOKEN_WORDS);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(TOKEN_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_TOK_WRITE,
        S_COPY,
        S_TOK_CHECK,
        S_FINISH
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic                mism_reg, mism_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    status_t             status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [USED_W-1:0]   rsp_used_reg, rsp_used_next;
    logic [LIFE_W-1:0]   lifetime_reg, lifetime_next;

    // request and hit payload
    op_t                 op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [ROLE_W-1:0]   role_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [WORD_W-1:0]   tok_word_reg [TOKEN_WORDS];
    logic [IW-1:0]       pidx_reg;
    logic [IW-1:0]       slot_reg;
    logic [EXPIRY_W-1:0] exp_reg;
    logic [ROLE_W-1:0]   srole_reg;

    // table memories
    logic [META_W-1:0]   meta_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]   tok_mem  [TDEPTH];
    logic [META_W-1:0]   meta_rd_reg;
    logic [WORD_W-1:0]   tok_rd_reg;
    logic                meta_we;
    logic [IW-1:0]       meta_waddr;
    logic [META_W-1:0]   meta_wdata;
    logic [IW-1:0]       meta_raddr;
    logic                tok_we;
    logic [TAW-1:0]      tok_waddr;
    logic [WORD_W-1:0]   tok_wdata;
    logic [TAW-1:0]      tok_raddr;

    // datapath
    logic                req_fire;
    logic                hit;
    logic                issue;
    logic [CW-1:0]       last_full;
    logic [IW-1:0]       last_idx;
    logic [WSEL_W-1:0]   wsel_cur;
    logic [WSEL_W-1:0]   wsel_prev;
    logic [WSEL_W-1:0]   tok_sel;
    logic [WORD_W-1:0]   tok_word_sel;
    logic [LEN_W-1:0]    len_c;
    logic [LEN_W-1:0]    len_lo;
    logic [LEN_W-1:0]    len_rem;
    logic [NB_W-1:0]     tok_nb;
    logic [EXPIRY_W-1:0] exp_new;
    logic [ID_W-1:0]     rd_ident;
    logic [WORD_W-1:0]   cmp_a;
    logic [WORD_W-1:0]   cmp_b;
    logic [NB_W-1:0]     cmp_nb;
    logic                cmp_eq;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.entries_used = rsp_used_reg;

    // indexes and token word selection
    assign last_full    = total_reg - CW'(1);
    assign last_idx     = last_full[IW-1:0];
    assign issue        = (idx_reg < total_reg);
    assign wsel_cur     = step_reg[WSEL_W-1:0];
    assign wsel_prev    = wsel_cur - WSEL_W'(1);
    assign tok_sel      = (state_reg == S_TOK_CHECK) ? wsel_prev : wsel_cur;
    assign tok_word_sel = tok_word_reg[tok_sel];
    assign rd_ident     = meta_rd_reg[META_W-1 -: ID_W];
    assign exp_new      = EXPIRY_W'(now_reg) + EXPIRY_W'(lifetime_reg);

    // bytes of the current token word that take part in the compare
    assign len_c   = (len_reg > LEN_MAX) ? LEN_MAX : len_reg;
    assign len_lo  = LEN_W'({wsel_prev, 3'b000});
    assign len_rem = len_c - len_lo;
    always_comb
    begin
        if (len_c <= len_lo)
            tok_nb = '0;
        else if (len_rem >= LEN_W'(WORD_BYTES))
            tok_nb = NB_W'(WORD_BYTES);
        else
            tok_nb = NB_W'(len_rem);
    end

    // shared compare operands: token word on check, id otherwise
    always_comb
    begin
        if (state_reg == S_TOK_CHECK)
        begin
            cmp_a  = tok_rd_reg;
            cmp_b  = tok_word_sel;
            cmp_nb = tok_nb;
        end
        else
        begin
            cmp_a  = WORD_W'(rd_ident);
            cmp_b  = WORD_W'(id_reg);
            cmp_nb = NB_W'(ID_BYTES);
        end
    end

    ctc_match u_match (
        .lhs    (cmp_a),
        .rhs    (cmp_b),
        .nbytes (cmp_nb),
        .eq     (cmp_eq)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        mism_next       = mism_reg;
        step_next       = step_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_used_next   = rsp_used_reg;
        lifetime_next   = cfg.valid ? cfg.token_lifetime : lifetime_reg;
        hit             = 1'b0;
        meta_we         = 1'b0;
        meta_waddr      = slot_reg;
        meta_wdata      = meta_rd_reg;
        meta_raddr      = last_idx;
        tok_we          = 1'b0;
        tok_waddr       = {slot_reg, wsel_prev};
        tok_wdata       = tok_rd_reg;
        tok_raddr       = {slot_reg, wsel_cur};

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                    state_next = S_DISPATCH;
            end

            S_DISPATCH:
            begin
                idx_next   = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
                state_next = S_FINISH;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        total_next  = '0;
                        status_next = ST_OK;
                    end
                    OP_REGISTER:
                    begin
                        if (total_reg >= DEPTH_C)
                            status_next = ST_INVALID;
                        else
                            state_next = S_SCAN;
                    end
                    OP_AUTHENTICATE:
                    begin
                        if (len_reg == '0)
                            status_next = ST_INVALID;
                        else
                            state_next = S_SCAN;
                    end
                    OP_REVOKE, OP_AUTHORIZE:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                    end
                endcase
            end

            // one read issued and one id compared per cycle
            S_SCAN:
            begin
                meta_raddr = idx_reg[IW-1:0];
                if (pend_reg && cmp_eq)
                begin
                    hit        = 1'b1;
                    found_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else if (!pend_reg && !issue)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                        idx_next = idx_reg + CW'(1);
                end
            end

            S_DECIDE:
            begin
                step_next  = '0;
                mism_next  = 1'b0;
                state_next = S_FINISH;
                case (op_reg)
                    OP_REGISTER:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_FAIL;
                        end
                        else
                        begin
                            meta_we    = 1'b1;
                            meta_waddr = total_reg[IW-1:0];
                            meta_wdata = {id_reg, role_reg, exp_new};
                            state_next = S_TOK_WRITE;
                        end
                    end
                    OP_REVOKE:
                    begin
                        if (found_reg)
                            state_next = S_COPY;
                        else
                            status_next = ST_FAIL;
                    end
                    OP_AUTHENTICATE:
                    begin
                        if (found_reg)
                            state_next = S_TOK_CHECK;
                        else
                            status_next = ST_AUTH;
                    end
                    OP_AUTHORIZE:
                    begin
                        if (!found_reg)
                            status_next = ST_AUTH;
                        else if (srole_reg < role_reg)
                            status_next = ST_DENIED;
                        else
                            status_next = ST_OK;
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                    end
                endcase
            end

            // new entry: token words written one a cycle
            S_TOK_WRITE:
            begin
                tok_we    = 1'b1;
                tok_waddr = {total_reg[IW-1:0], wsel_cur};
                tok_wdata = tok_word_sel;
                if (step_reg == STEP_LAST)
                begin
                    total_next  = total_reg + CW'(1);
                    status_next = ST_OK;
                    state_next  = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            // revoke: last entry moved into the freed slot
            S_COPY:
            begin
                tok_raddr = {last_idx, wsel_cur};
                if (step_reg == '0)
                    meta_we = 1'b1;
                else
                    tok_we = 1'b1;
                if (step_reg == STEP_END)
                begin
                    total_next  = last_full;
                    status_next = ST_OK;
                    state_next  = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            // authenticate: token words compared one a cycle, then expiry
            S_TOK_CHECK:
            begin
                if (step_reg != '0)
                    mism_next = mism_reg || !cmp_eq;
                if (step_reg == STEP_END)
                begin
                    if (mism_reg || !cmp_eq)
                        status_next = ST_AUTH;
                    else if (exp_reg < EXPIRY_W'(now_reg))
                        status_next = ST_EXPIRED;
                    else
                        status_next = ST_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_used_next   = USED_W'(total_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            mism_reg       <= 1'b0;
            step_reg       <= '0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
            rsp_status_reg <= '0;
            rsp_used_reg   <= '0;
            lifetime_reg   <= LIFETIME_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            mism_reg       <= mism_next;
            step_reg       <= step_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_used_reg   <= rsp_used_next;
            lifetime_reg   <= lifetime_next;
        end
    end

    // request word and hit entry capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg          <= op_t'(req.op);
            id_reg          <= req.user_id;
            role_reg        <= req.role;
            len_reg         <= req.match_len;
            now_reg         <= req.now;
            tok_word_reg[0] <= req.token_word0;
            tok_word_reg[1] <= req.token_word1;
            tok_word_reg[2] <= req.token_word2;
            tok_word_reg[3] <= req.token_word3;
        end
        if (state_reg == S_SCAN)
            pidx_reg <= idx_reg[IW-1:0];
        if (hit)
        begin
            slot_reg  <= pidx_reg;
            srole_reg <= meta_rd_reg[EXPIRY_W +: ROLE_W];
            exp_reg   <= meta_rd_reg[EXPIRY_W-1:0];
        end
    end

    // id, role and expiry memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        meta_rd_reg <= meta_mem[meta_raddr];
    end

    // token memory, four words per entry
    always_ff @(posedge clk)
    begin
        if (tok_we)
            tok_mem[tok_waddr] <= tok_wdata;
        tok_rd_reg <= tok_mem[tok_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/ctc_match.sv -----
// ----------------------------------------------------------------------------
// ctc_match - shared masked compare unit
// Compares the low nbytes bytes of two 64-bit words; used for the id scan
// and for each token word in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_match (
    input  logic [ctc_pkg::WORD_W-1:0] lhs,
    input  logic [ctc_pkg::WORD_W-1:0] rhs,
    input  logic [ctc_pkg::NB_W-1:0]   nbytes,
    output logic                       eq
);
    import ctc_pkg::*;

    logic [WORD_W-1:0] mask;

    // byte enable mask from the byte count
    always_comb
    begin
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            mask[i*BYTE_W +: BYTE_W] = (NB_W'(i) < nbytes) ? '1 : '0;
        end
    end

    assign eq = (((lhs ^ rhs) & mask) == '0);

endmodule

`default_nettype wire

// ----- sv/ctc_checker.sv -----
// ----------------------------------------------------------------------------
// ctc_checker - port level checks of the credential table
// Watches the request and response handshakes of the top level; bound to it
// below.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [ctc_pkg::STATUS_W-1:0] rsp_status,
    input logic [ctc_pkg::USED_W-1:0]   rsp_entries_used
);
    import ctc_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_entries_used))
        else $error("response word changed while stalled");

    // one request in flight: ready drops after an accepted word
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= STATUS_W'(ST_FAIL))
        else $error("undefined status code");

    // the table never reports more entries than it holds
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (TABLE_DEPTH >= 32) || (int'(rsp_entries_used) <= TABLE_DEPTH))
        else $error("entry count above table depth");

endmodule

bind credential_table_check ctc_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ctc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_entries_used (rsp.entries_used)
);

`default_nettype wire
